### design/iaq_pkg.sv
// Package for the image acquire queue: sizes, operation and status codes.
// No dependencies; imported by every module of the block except iaq_ram.

package iaq_pkg;

    // Ring size and stored handle width.
    localparam int QUEUE_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 16;

    // Derived index and count widths; a pointer plus a count stays below twice the depth.
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Field widths of the transfers.
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;
    localparam int IO_HANDLE_W  = 16;
    localparam int LIMIT_W      = 8;
    localparam int IN_TDATA_W   = ((OP_W + IO_HANDLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((ST_W + IO_HANDLE_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - ST_W - IO_HANDLE_W;

    // Operation codes carried in the input transfer.
    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE     = 3'd0,
        OP_ACQ_OLDEST  = 3'd1,
        OP_ACQ_LATEST  = 3'd2,
        OP_RELEASE     = 3'd3,
        OP_CLOSE       = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_LIMIT    = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    // Decision made at acceptance, carried alongside the ring read.
    typedef struct packed {
        status_t status;
        logic    take;
    } decision_t;

endpackage

### design/iaq_ram.sv
// Simple dual-port RAM holding the pending frame handles.
// One write and one registered read per cycle; no package dependency.

module iaq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is enabled.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/image_acquire_queue_core.sv
// Image acquire queue: frame-handle FIFO with an acquisition budget.
// Depends on iaq_pkg and iaq_ram.
//
// Usage:
// - The s_ channel carries one operation per transfer (enqueue, acquire
//   oldest, acquire latest, release, close) with a frame handle.
// - Every accepted transfer produces exactly one result transfer on the m_
//   channel, in order, holding a status and the acquired handle.
// - cfg_we writes the frame limit (a value of zero acts as one); write it only
//   while the block is idle.
// - All decisions and queue updates are made in the cycle of acceptance, so
//   one operation is taken every cycle while the result stream is not stalled.
// - On its way to m_tvalid a result passes the registered read of the handle
//   ring, taken with the decision stage, and then the output register.
// - When the receiver stalls, the output register holds its transfer and the
//   decision stage behind it fills; s_tready then drops until m_tready rises.
// - Reset empties the queue, clears the acquired count, reopens the queue and
//   sets the frame limit to one. The ring contents are not cleared.

module image_acquire_queue_core
    import iaq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration: frame limit.
    input  logic                   cfg_we,
    input  logic [LIMIT_W-1:0]     cfg_wdata,
    // Operation stream. tdata fields from bit 0: op[2:0], frame_handle[18:3], zero pad.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream. tdata fields from bit 0: status[1:0], acquired_handle[17:2], zero pad.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Queue state.
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] acq_reg, acq_next;
    logic               closed_reg, closed_next;
    logic [LIMIT_W-1:0] max_reg;

    // Decision stage and output register.
    logic               p1_valid_reg;
    decision_t          p1_reg, dec_next;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [IO_HANDLE_W-1:0] m_handle_reg;

    logic               accept;
    logic               out_ready;
    op_t                op;
    logic [IO_HANDLE_W-1:0] in_handle;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] free_slots;
    logic [SUM_W-1:0]   wr_sum, tail_sum;
    logic [PTR_W-1:0]   wr_idx, tail_idx, head_inc;
    logic               ram_we;
    logic [PTR_W-1:0]   rd_addr;
    logic [HANDLE_WIDTH-1:0] rd_data;

    // Handshake: the output register frees when empty or taken; the
    // decision stage frees when empty or moving on.
    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;

    assign op        = op_t'(s_tdata[OP_W-1:0]);
    assign in_handle = s_tdata[OP_W +: IO_HANDLE_W];

    // Budget and free slots; free slots is only used while acq_reg < lim.
    assign lim        = (max_reg == '0) ? LIMIT_W'(1) : max_reg;
    assign free_slots = lim - acq_reg;

    // Ring indices with wrap at the queue depth.
    assign wr_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_sum = wr_sum - SUM_W'(1);
    assign wr_idx   = (wr_sum >= SUM_W'(QUEUE_DEPTH))
                      ? PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(wr_sum);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);

    // Operation decode and next queue state.
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        acq_next    = acq_reg;
        closed_next = closed_reg;
        dec_next    = '{status: ST_REJECTED, take: 1'b0};
        ram_we      = 1'b0;
        rd_addr     = head_reg;
        unique case (op)
            OP_ENQUEUE: begin
                if (!closed_reg && count_reg != CNT_W'(QUEUE_DEPTH)) begin
                    ram_we          = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    dec_next.status = ST_OK;
                end
            end
            OP_ACQ_OLDEST, OP_ACQ_LATEST: begin
                if (closed_reg) begin
                    dec_next.status = ST_NO_FRAME;
                end else if (acq_reg >= lim) begin
                    dec_next.status = ST_LIMIT;
                end else if (count_reg == '0) begin
                    dec_next.status = ST_NO_FRAME;
                end else begin
                    dec_next.status = ST_OK;
                    dec_next.take   = 1'b1;
                    acq_next        = acq_reg + LIMIT_W'(1);
                    if (op == OP_ACQ_LATEST && free_slots >= LIMIT_W'(2)) begin
                        // Take the newest and drop everything older.
                        rd_addr    = tail_idx;
                        head_next  = '0;
                        count_next = '0;
                    end else begin
                        rd_addr    = head_reg;
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_RELEASE: begin
                if (acq_reg != '0) begin
                    acq_next        = acq_reg - LIMIT_W'(1);
                    dec_next.status = ST_OK;
                end
            end
            OP_CLOSE: begin
                closed_next     = 1'b1;
                head_next       = '0;
                count_next      = '0;
                dec_next.status = ST_OK;
            end
            default: begin
                dec_next.status = ST_REJECTED;
            end
        endcase
    end

    // Handle ring.
    iaq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (HANDLE_WIDTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (accept && ram_we),
        .wr_addr (wr_idx),
        .wr_data (HANDLE_WIDTH'(in_handle)),
        .rd_en   (accept && dec_next.take),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Queue state and configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            acq_reg    <= '0;
            closed_reg <= 1'b0;
            max_reg    <= LIMIT_W'(1);
        end else begin
            if (accept) begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                acq_reg    <= acq_next;
                closed_reg <= closed_next;
            end
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    // Decision stage; its payload moves only on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (out_ready) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= dec_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p1_valid_reg) begin
            m_status_reg <= p1_reg.status;
            m_handle_reg <= p1_reg.take ? IO_HANDLE_W'(rd_data) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_handle_reg, m_status_reg};

endmodule

### design/iaq_checker.sv
// Port-level checks for image_acquire_queue_core, attached by bind.
// Depends on iaq_pkg for widths and status codes.

module iaq_checker
    import iaq_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // No result is presented in the cycle after reset, and input is open.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result or stall present straight after reset");

    // A result is showing once an accepted transfer has passed the decision stage and the output register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result missing two cycles after acceptance");

    // A result with a status other than ok carries a zero handle.
    a_zero_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ST_W-1:0] != ST_OK |-> m_tdata[ST_W +: IO_HANDLE_W] == '0)
        else $error("handle given with a non-ok status");

    // A stalled result holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind image_acquire_queue_core iaq_checker u_iaq_checker (.*);

### test/testbench.sv
// Self-checking testbench for image_acquire_queue_core: drives operations with random
// idling on both streams and checks every result against a behavioural queue tracker.
// Depends on iaq_pkg and the design sources only.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import iaq_pkg::*;

    // Reserved operation codes, which the block must reject.
    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;
    localparam logic [IO_HANDLE_W-1:0] HANDLE_ALL_ONES = '1;

    // Relative weights of the operations drawn in one random phase.
    typedef struct packed {
        int enq;
        int oldest;
        int latest;
        int rel;
        int close_w;
        int bad;
    } op_mix_t;

    // Expected result of one operation.
    typedef struct packed {
        status_t               status;
        logic [IO_HANDLE_W-1:0] handle;
    } queue_result_t;

    // Tracks the queue state and holds the results still owed by the block.
    class frame_queue_tracker;
        logic [HANDLE_WIDTH-1:0] ring [QUEUE_DEPTH];
        logic [3:0]              head;
        logic [4:0]              count;
        logic [7:0]              acquired;
        logic                    closed;
        logic [LIMIT_W-1:0]      frame_limit;
        queue_result_t           owed_results [$];
        int                      errors;

        function new();
            head        = '0;
            count       = '0;
            acquired    = '0;
            closed      = 1'b0;
            frame_limit = 8'd1;
            errors      = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Applies one accepted operation and queues the result it must give.
        function void note_operation(input logic [OP_W-1:0] op,
                                     input logic [IO_HANDLE_W-1:0] handle);
            queue_result_t res;
            int            budget;
            logic [3:0]    slot;
            budget     = (frame_limit == 0) ? 1 : int'(frame_limit);
            res.status = ST_REJECTED;
            res.handle = '0;
            case (op)
                OP_ENQUEUE: begin
                    if (!closed && count < QUEUE_DEPTH) begin
                        slot       = head + count[3:0];
                        ring[slot] = handle;
                        count      = count + 5'd1;
                        res.status = ST_OK;
                    end
                end
                OP_ACQ_OLDEST, OP_ACQ_LATEST: begin
                    if (closed) begin
                        res.status = ST_NO_FRAME;
                    end else if (int'(acquired) >= budget) begin
                        res.status = ST_LIMIT;
                    end else if (count == 0) begin
                        res.status = ST_NO_FRAME;
                    end else begin
                        // The newest frame is only taken when two slots are free.
                        if (op == OP_ACQ_LATEST && budget - int'(acquired) >= 2) begin
                            slot       = head + count[3:0] - 4'd1;
                            res.handle = ring[slot];
                            head       = '0;
                            count      = '0;
                        end else begin
                            res.handle = ring[head];
                            head       = head + 4'd1;
                            count      = count - 5'd1;
                        end
                        acquired   = acquired + 8'd1;
                        res.status = ST_OK;
                    end
                end
                OP_RELEASE: begin
                    if (acquired != 0) begin
                        acquired   = acquired - 8'd1;
                        res.status = ST_OK;
                    end
                end
                OP_CLOSE: begin
                    closed     = 1'b1;
                    head       = '0;
                    count      = '0;
                    res.status = ST_OK;
                end
                default: ;
            endcase
            owed_results = {owed_results, res};
        endfunction

        // Compares one result transfer with the oldest owed result.
        task check_result(input logic [OUT_TDATA_W-1:0] tdata);
            queue_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result 0x%06h with nothing outstanding", tdata));
            end else begin
                want = owed_results[0];
                owed_results.delete(0);
                if (tdata[ST_W-1:0] !== want.status)
                    report($sformatf("status %0d, expected %0d", tdata[ST_W-1:0],
                                     want.status));
                if (tdata[ST_W +: IO_HANDLE_W] !== want.handle)
                    report($sformatf("handle 0x%04h, expected 0x%04h",
                                     tdata[ST_W +: IO_HANDLE_W], want.handle));
            end
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    frame_queue_tracker queue_model = new();
    int                 src_calm    = 0;

    image_acquire_queue_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offers one operation after a random gap and waits for its transfer.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [IO_HANDLE_W-1:0] handle);
        int gap;
        gap = (src_calm > 0) ? 0 : $urandom_range(0, 6);
        if (src_calm > 0)
            src_calm--;
        else if ($urandom_range(0, 39) == 0)
            src_calm = $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - OP_W - IO_HANDLE_W){1'b0}}, handle, op};
        do @(posedge aclk); while (!s_tready);
        queue_model.note_operation(op, handle);
    endtask

    // Lets every outstanding result drain, plus the pipeline latency.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (queue_model.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the frame limit once the block has gone quiet.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        queue_model.frame_limit = value;
    endtask

    function automatic logic [OP_W-1:0] draw_op(input op_mix_t mix);
        int pick;
        pick = $urandom_range(0, mix.enq + mix.oldest + mix.latest + mix.rel
                                 + mix.close_w + mix.bad - 1);
        if (pick < mix.enq) return OP_ENQUEUE;
        pick -= mix.enq;
        if (pick < mix.oldest) return OP_ACQ_OLDEST;
        pick -= mix.oldest;
        if (pick < mix.latest) return OP_ACQ_LATEST;
        pick -= mix.latest;
        if (pick < mix.rel) return OP_RELEASE;
        pick -= mix.rel;
        if (pick < mix.close_w) return OP_CLOSE;
        return OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    endfunction

    function automatic logic [IO_HANDLE_W-1:0] draw_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return HANDLE_ALL_ONES;
            default: return IO_HANDLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // One random phase at a given limit and operation mix.
    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int items,
                             input op_mix_t mix);
        write_limit(limit);
        repeat (items) send_op(draw_op(mix), draw_handle());
    endtask

    // Result side: random stalls with occasional stretches of steady acceptance.
    initial begin
        int stall;
        int calm;
        calm = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = (calm > 0) ? 0 : $urandom_range(0, 6);
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 39) == 0)
                calm = $urandom_range(10, 40);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            queue_model.check_result(m_tdata);
        end
    end

    // Main sequence: reset, directed cases, random phases, final drain.
    initial begin
        logic [OP_W-1:0] code;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset limit of one: empty queue, FIFO fallback, limit and bad releases.
        send_op(OP_RELEASE,    16'h0000);
        send_op(OP_ACQ_OLDEST, 16'h0000);
        send_op(OP_ACQ_LATEST, HANDLE_ALL_ONES);
        send_op(OP_ENQUEUE,    16'h0000);
        send_op(OP_ENQUEUE,    HANDLE_ALL_ONES);
        send_op(OP_ACQ_LATEST, 16'h0000);
        send_op(OP_ACQ_OLDEST, 16'h0000);
        send_op(OP_RELEASE,    16'h0000);
        send_op(OP_ACQ_OLDEST, 16'h0000);
        send_op(OP_RELEASE,    HANDLE_ALL_ONES);
        for (code = OP_RESERVED_FIRST; code != OP_RESERVED_FIRST - 3'd1; code++) begin
            send_op(code, HANDLE_ALL_ONES);
            if (code == OP_RESERVED_LAST)
                break;
        end

        // Limit of three: newest taken with a flush, then FIFO with one slot left.
        write_limit(8'd3);
        send_op(OP_ENQUEUE,    16'h5555);
        send_op(OP_ENQUEUE,    16'hAAAA);
        send_op(OP_ENQUEUE,    16'h1234);
        send_op(OP_ACQ_LATEST, 16'h0000);
        send_op(OP_ACQ_OLDEST, 16'h0000);
        send_op(OP_ENQUEUE,    16'h8001);
        send_op(OP_ENQUEUE,    16'h7FFE);
        send_op(OP_ACQ_LATEST, 16'h0000);
        send_op(OP_ENQUEUE,    16'h0F0F);
        send_op(OP_ENQUEUE,    16'hF0F0);
        send_op(OP_ACQ_LATEST, 16'h0000);
        send_op(OP_RELEASE,    16'h0000);

        // Random phases; close appears only in the last, as it latches until reset.
        run_phase(8'd2,   180, '{enq: 40, oldest: 20, latest: 15, rel: 20, close_w: 0, bad: 5});
        run_phase(8'd0,   170, '{enq: 70, oldest: 10, latest: 8,  rel: 8,  close_w: 0, bad: 4});
        run_phase(8'd1,   150, '{enq: 40, oldest: 20, latest: 20, rel: 16, close_w: 0, bad: 4});
        run_phase(8'd255, 280, '{enq: 50, oldest: 30, latest: 12, rel: 5,  close_w: 0, bad: 3});
        run_phase(LIMIT_W'($urandom_range(1, 254)), 220,
                  '{enq: 40, oldest: 15, latest: 15, rel: 22, close_w: 3, bad: 5});

        // Drain, allow for the output latency, then settle the verdict.
        wait_idle();
        repeat (10) @(posedge aclk);
        if (queue_model.pending() != 0)
            queue_model.report($sformatf("%0d results never arrived", queue_model.pending()));
        if (queue_model.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
design/iaq_pkg.sv
design/iaq_ram.sv
design/image_acquire_queue_core.sv
design/iaq_checker.sv
test/testbench.sv
